/* rtl/core/lru_pkg.sv */
// Shared types and constants for the LRU tag store.
`default_nettype none
package lru_pkg;
    localparam int ENTRIES    = 16;
    localparam int KEY_WIDTH  = 64;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [2:0] ACT_GET      = 3'd0;
    localparam logic [2:0] ACT_PUT      = 3'd1;
    localparam logic [2:0] ACT_CONTAINS = 3'd2;
    localparam logic [2:0] ACT_REMOVE   = 3'd3;
    localparam logic [2:0] ACT_CLEAR    = 3'd4;
    localparam logic [2:0] ACT_RESIZE   = 3'd5;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] key;
        logic [4:0]  new_capacity;
    } lru_in_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic [4:0]  entry_count;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
    } lru_out_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture input item
        logic exec;      // apply main action
        logic evict;     // drop least recent entry
        logic finish;    // build result
    } lru_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic need_evict;
    } lru_sts_t;
endpackage
`default_nettype wire

/* rtl/core/lru_tag_store.sv */
// Top level of the LRU tag store.
//
// Fully associative tag store with least-recently-used replacement.
// s_ channel: one item (action, key, new_capacity) per transfer.
// m_ channel: one result per item (hit, slot, entry_count, counters).
// The result is registered after an eviction check state, then an
// execute state. Each put at capacity or shrinking resize passes
// through the evict state once per evicted entry (the single-victim evict step).
// One item is in work at a time; the next is taken once the result
// register is free or being drained in the same cycle.
// Reset (aresetn low, synchronous) empties the table, zeroes the
// counters and sets capacity to the full entry count.
// If the receiver stalls, the result holds and no new item is taken.
`default_nettype none
module lru_tag_store (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire lru_pkg::lru_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output lru_pkg::lru_out_t     m_data
);
    import lru_pkg::*;

    lru_cmd_t cmd;
    lru_sts_t sts;

    lru_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .sts, .cmd
    );

    lru_dpath u_dpath (
        .aclk, .aresetn, .s_data, .cmd, .sts, .m_data
    );
endmodule
`default_nettype wire

/* rtl/core/lru_ctrl.sv */
// Controller state machine for the LRU tag store.
`default_nettype none
module lru_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire lru_pkg::lru_sts_t sts,
    output lru_pkg::lru_cmd_t    cmd
);
    import lru_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVICT = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       mval_reg, mval_next;

    // accept when idle and the output slot is free or draining
    assign s_ready = (state_reg == ST_IDLE) && (!mval_reg || m_ready);
    assign m_valid = mval_reg;

    always_comb begin
        state_next = state_reg;
        mval_next  = mval_reg;
        cmd        = '0;
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT: begin
                if (sts.need_evict) begin
                    cmd.evict = 1'b1;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                cmd.finish = 1'b1;
                mval_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mval_reg  <= mval_next;
        end
    end

    // result only appears out of the execute state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(mval_reg) |-> $past(state_reg) == ST_EXEC)
        else $error("result without execute");
    // no new item while a result is stuck
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mval_reg && !m_ready) |-> !s_ready)
        else $error("accept over stalled result");
    // execute never directly follows idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXEC |-> $past(state_reg) == ST_EVICT)
        else $error("execute skipped eviction check");
endmodule
`default_nettype wire

/* rtl/core/lru_dpath.sv */
// Datapath of the LRU tag store: tags, ranks, counters and result.
`default_nettype none
module lru_dpath (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lru_pkg::lru_in_t s_data,
    input  wire lru_pkg::lru_cmd_t cmd,
    output lru_pkg::lru_sts_t     sts,
    output lru_pkg::lru_out_t     m_data
);
    import lru_pkg::*;

    logic [ENTRIES-1:0]   valid_reg;
    logic [KEY_WIDTH-1:0] key_reg [ENTRIES];
    logic [IDX_W-1:0]     rank_reg [ENTRIES];
    logic [CNT_W-1:0]     cap_reg, total_reg;
    logic [31:0]          hits_reg, miss_reg;
    lru_in_t              item_reg;
    logic                 hit_out_reg;
    logic [3:0]           slot_out_reg;

    logic [ENTRIES-1:0]   match, lru_sel;
    logic                 found, have_free;
    logic [IDX_W-1:0]     found_idx, free_idx, lru_idx, found_rank, lru_rank;
    logic [CNT_W-1:0]     rcap;
    logic                 is_put_miss;

    // saturated resize capacity
    always_comb begin
        rcap = item_reg.new_capacity[CNT_W-1:0];
        if (item_reg.new_capacity == 5'd0) rcap = CNT_W'(1);
        if (32'(item_reg.new_capacity) > ENTRIES) rcap = CNT_W'(ENTRIES);
    end

    // parallel compare, free and least-recent search
    always_comb begin
        found = 1'b0; found_idx = '0; have_free = 1'b0; free_idx = '0;
        lru_idx = '0; match = '0; lru_sel = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i]   = valid_reg[i] &&
                         key_reg[i] == item_reg.key[KEY_WIDTH-1:0];
            lru_sel[i] = valid_reg[i] &&
                         CNT_W'(rank_reg[i]) + CNT_W'(1) == total_reg;
            if (match[i])   begin found = 1'b1; found_idx = IDX_W'(i); end
            if (!valid_reg[i]) begin have_free = 1'b1; free_idx = IDX_W'(i); end
            if (lru_sel[i]) lru_idx = IDX_W'(i);
        end
        found_rank = rank_reg[found_idx];
        lru_rank   = rank_reg[lru_idx];
    end

    assign is_put_miss = item_reg.action == ACT_PUT && !found;
    assign sts.need_evict = total_reg != '0 &&
        ((is_put_miss && total_reg >= cap_reg) ||
         (item_reg.action == ACT_RESIZE && total_reg > rcap));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            cap_reg   <= CNT_W'(ENTRIES);
            total_reg <= '0;
            hits_reg  <= '0;
            miss_reg  <= '0;
        end else if (cmd.evict) begin
            // drop least recent, close the rank gap
            valid_reg[lru_idx] <= 1'b0;
            total_reg <= total_reg - CNT_W'(1);
            for (int i = 0; i < ENTRIES; i++)
                if (valid_reg[i] && rank_reg[i] > lru_rank)
                    rank_reg[i] <= rank_reg[i] - IDX_W'(1);
        end else if (cmd.exec) begin
            case (item_reg.action)
                ACT_GET, ACT_PUT: begin
                    if (found) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i] && rank_reg[i] < found_rank)
                                rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                        rank_reg[found_idx] <= '0;
                        if (item_reg.action == ACT_GET && hits_reg != COUNT_MAX)
                            hits_reg <= hits_reg + 32'd1;
                    end else if (item_reg.action == ACT_GET) begin
                        if (miss_reg != COUNT_MAX) miss_reg <= miss_reg + 32'd1;
                    end else if (have_free) begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i]) rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                        valid_reg[free_idx] <= 1'b1;
                        key_reg[free_idx]   <= item_reg.key[KEY_WIDTH-1:0];
                        rank_reg[free_idx]  <= '0;
                        total_reg <= total_reg + CNT_W'(1);
                    end
                end
                ACT_REMOVE: begin
                    if (found) begin
                        valid_reg[found_idx] <= 1'b0;
                        total_reg <= total_reg - CNT_W'(1);
                        for (int i = 0; i < ENTRIES; i++)
                            if (valid_reg[i] && rank_reg[i] > found_rank)
                                rank_reg[i] <= rank_reg[i] - IDX_W'(1);
                    end
                end
                ACT_CLEAR: begin
                    valid_reg <= '0;
                    total_reg <= '0;
                    hits_reg  <= '0;
                    miss_reg  <= '0;
                end
                ACT_RESIZE: cap_reg <= rcap;
                default: ;
            endcase
        end
    end

    // item capture and result assembly (payload, no reset)
    always_ff @(posedge aclk) begin
        if (cmd.load) item_reg <= s_data;
        if (cmd.finish) begin
            hit_out_reg  <= (item_reg.action == ACT_GET || item_reg.action == ACT_PUT ||
                             item_reg.action == ACT_CONTAINS ||
                             item_reg.action == ACT_REMOVE) && found;
            slot_out_reg <= '0;
            if ((item_reg.action == ACT_GET || item_reg.action == ACT_PUT) && found)
                slot_out_reg <= 4'(found_idx);
            else if (is_put_miss && have_free)
                slot_out_reg <= 4'(free_idx);
        end
    end

    // counters are live state, final after exec
    assign m_data.hit         = hit_out_reg;
    assign m_data.slot        = slot_out_reg;
    assign m_data.entry_count = 5'(total_reg);
    assign m_data.hit_count   = hits_reg;
    assign m_data.miss_count  = miss_reg;

    // a key is never held twice
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(match) <= 1) else $error("duplicate key");
    // occupancy matches valid bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(total_reg)) else $error("count mismatch");
    // eviction only with a least recent entry present
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict |-> $onehot(lru_sel)) else $error("no victim");
endmodule
`default_nettype wire

/* bench/lru_tag_store_test.sv */
// Self-checking testbench for the LRU tag store: random and directed actions against a model.
`default_nettype none
module lru_tag_store_test;
    import lru_pkg::*;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lru_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lru_out_t m_data;

    lru_tag_store dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor state
    bit          tbl_valid [ENTRIES];
    logic [63:0] tbl_key   [ENTRIES];
    int unsigned tbl_rank  [ENTRIES];
    int unsigned cap_lim;
    int unsigned live;
    logic [31:0] hits;
    logic [31:0] misses;

    lru_in_t  pending_items [$];
    lru_out_t expected_results [$];
    int       errors = 0;
    int       cycles = 0;
    bit       stim_done = 1'b0;
    bit       calm = 1'b0;
    logic [63:0] key_pool [8];

    function automatic int find_entry(logic [63:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void promote(int e);
        int unsigned r;
        r = tbl_rank[e];
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_rank[i] < r) tbl_rank[i]++;
        tbl_rank[e] = 0;
    endfunction

    function automatic void drop(int e);
        int unsigned r;
        r = tbl_rank[e];
        tbl_valid[e] = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
        if (live > 0) live--;
    endfunction

    function automatic void evict_oldest();
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_rank[i] + 1 == live) begin
                drop(i);
                return;
            end
    endfunction

    function automatic int insert(logic [63:0] k);
        int fs;
        fs = -1;
        while (live >= cap_lim && live > 0) evict_oldest();
        for (int i = 0; i < ENTRIES; i++)
            if (!tbl_valid[i] && fs < 0) fs = i;
        if (fs < 0) return 0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i]) tbl_rank[i]++;
        tbl_valid[fs] = 1'b1;
        tbl_key[fs] = k;
        tbl_rank[fs] = 0;
        live++;
        return fs;
    endfunction

    // compute result of one action and advance predictor state
    function automatic lru_out_t lookup_update(lru_in_t it);
        lru_out_t r;
        int e;
        int unsigned c;
        r = '0;
        e = find_entry(it.key);
        case (it.action)
            ACT_GET: begin
                if (e >= 0) begin
                    promote(e);
                    if (hits != COUNT_MAX) hits++;
                    r.hit = 1'b1;
                    r.slot = e[3:0];
                end else if (misses != COUNT_MAX) misses++;
            end
            ACT_PUT: begin
                if (e >= 0) begin
                    promote(e);
                    r.hit = 1'b1;
                    r.slot = e[3:0];
                end else begin
                    e = insert(it.key);
                    r.slot = e[3:0];
                end
            end
            ACT_CONTAINS: r.hit = (e >= 0);
            ACT_REMOVE: if (e >= 0) begin
                drop(e);
                r.hit = 1'b1;
            end
            ACT_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
                live = 0;
                hits = '0;
                misses = '0;
            end
            ACT_RESIZE: begin
                c = it.new_capacity;
                if (c == 0) c = 1;
                if (c > ENTRIES) c = ENTRIES;
                cap_lim = c;
                while (live > cap_lim) evict_oldest();
            end
            default: ;
        endcase
        r.entry_count = live[4:0];
        r.hit_count = hits;
        r.miss_count = misses;
        return r;
    endfunction

    function automatic void add(logic [2:0] a, logic [63:0] k, logic [4:0] c);
        lru_in_t it;
        it.action = a;
        it.key = k;
        it.new_capacity = c;
        pending_items.push_back(it);
    endfunction

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    initial begin
        forever #4 aclk = ~aclk;
    end

    // stimulus
    initial begin
        logic [2:0] a;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_rank[i] = 0;
        end
        cap_lim = ENTRIES;
        live = 0;
        hits = '0;
        misses = '0;
        key_pool[0] = 64'h8000_0000_0000_0000;
        key_pool[1] = 64'h7FFF_FFFF_FFFF_FFFF;
        key_pool[2] = 64'h0;
        key_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 4; i < 8; i++) key_pool[i] = rand_key();

        // directed: extremes, every action, unused codes, capacity corners
        add(ACT_GET, key_pool[0], 5'd0);
        add(ACT_PUT, key_pool[0], 5'd0);
        add(ACT_PUT, key_pool[1], 5'd31);
        add(ACT_PUT, key_pool[2], 5'd0);
        add(ACT_PUT, key_pool[3], 5'd0);
        add(ACT_GET, key_pool[1], 5'd0);
        add(ACT_CONTAINS, key_pool[3], 5'd0);
        add(ACT_CONTAINS, 64'h1234, 5'd0);
        add(ACT_REMOVE, key_pool[2], 5'd0);
        add(ACT_REMOVE, key_pool[2], 5'd0);
        add(ACT_PUT, 64'h55, 5'd0);
        add(3'd6, key_pool[0], 5'd0);
        add(3'd7, key_pool[1], 5'd31);
        add(ACT_RESIZE, 64'h0, 5'd0);
        add(ACT_PUT, 64'h77, 5'd0);
        add(ACT_RESIZE, 64'h0, 5'd31);
        add(ACT_RESIZE, 64'h0, 5'd16);
        for (int i = 0; i < 18; i++) add(ACT_PUT, 64'h100 + i, 5'd0);
        add(ACT_RESIZE, 64'h0, 5'd3);
        add(ACT_CLEAR, 64'h0, 5'd0);
        add(ACT_GET, 64'h101, 5'd0);

        // random: mostly keys from a small pool so hits and evictions happen
        for (int n = 0; n < 1250; n++) begin
            if (n % 60 == 0)
                for (int i = 4; i < 8; i++) key_pool[i] = rand_key();
            case ($urandom_range(0, 99)) inside
                [0:29]:  a = ACT_GET;
                [30:59]: a = ACT_PUT;
                [60:72]: a = ACT_CONTAINS;
                [73:84]: a = ACT_REMOVE;
                [85:86]: a = ACT_CLEAR;
                [87:96]: a = ACT_RESIZE;
                default: a = 3'($urandom_range(6, 7));
            endcase
            add(a, ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] +
                64'($urandom_range(0, 7)) : rand_key(), 5'($urandom));
        end
        stim_done = 1'b1;
    end

    // reset and run control
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        calm <= (cycles > 3000 && cycles < 5000);
        if (cycles == 3) aresetn <= 1'b1;
        if (cycles > 400000) begin
            $display("lru_tag_store test failed");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
                    s_data <= pending_items[0];
                    expected_results.push_back(lookup_update(pending_items[0]));
                    void'(pending_items.pop_front());
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 23);
        end
    end

    // monitor
    always @(posedge aclk) begin
        lru_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_data.hit !== exp_r.hit) begin
                    $display("%0t: hit exp %h got %h", $time, exp_r.hit, m_data.hit);
                    errors++;
                end
                if (m_data.slot !== exp_r.slot) begin
                    $display("%0t: slot exp %h got %h", $time, exp_r.slot, m_data.slot);
                    errors++;
                end
                if (m_data.entry_count !== exp_r.entry_count) begin
                    $display("%0t: entry_count exp %0d got %0d", $time,
                             exp_r.entry_count, m_data.entry_count);
                    errors++;
                end
                if (m_data.hit_count !== exp_r.hit_count) begin
                    $display("%0t: hit_count exp %0d got %0d", $time,
                             exp_r.hit_count, m_data.hit_count);
                    errors++;
                end
                if (m_data.miss_count !== exp_r.miss_count) begin
                    $display("%0t: miss_count exp %0d got %0d", $time,
                             exp_r.miss_count, m_data.miss_count);
                    errors++;
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        @(posedge aclk);
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("lru_tag_store test passed");
        end else begin
            $display("lru_tag_store test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
